// ----- rtl/mbe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, codes and transaction types of the escape-time colouriser.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 10;

    localparam int PIX_BITS       = 12;
    localparam int CFG_COORD_BITS = 32;
    localparam int STEP_BITS      = 31;
    localparam int COLOR_BITS     = 8;
    localparam int SCHEME_BITS    = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 3;

    function automatic int max_of(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // pixel to coordinate mapping, wide enough that nothing wraps before saturation
    localparam int MAP_W = max_of(max_of(PIX_BITS + STEP_BITS + 1, CFG_COORD_BITS),
                                  COORD_BITS) + 1;

    // |z| parts are within +-2 once a candidate passes the bound check
    localparam int Z_W    = FRAC_BITS + 3;
    localparam int PROD_W = 2 * Z_W;
    localparam int SQ_W   = FRAC_BITS + 3;
    localparam int P_W    = FRAC_BITS + 4;
    localparam int SUM_W  = FRAC_BITS + 4;
    localparam int NW     = max_of(FRAC_BITS + 5, COORD_BITS) + 1;

    localparam logic signed [NW-1:0] Z_TWO   = NW'(1) << (FRAC_BITS + 1);
    localparam logic [SUM_W-1:0]     SQ_FOUR = SUM_W'(1) << (FRAC_BITS + 2);

    // mixed scheme: channel = (count mod m) * (256 / m)
    localparam int MIX_R_MOD  = 4;
    localparam int MIX_G_MOD  = 8;
    localparam int MIX_B_MOD  = 12;
    localparam int MIX_R_STEP = (2 ** COLOR_BITS) / MIX_R_MOD;
    localparam int MIX_G_STEP = (2 ** COLOR_BITS) / MIX_G_MOD;
    localparam int MIX_B_STEP = (2 ** COLOR_BITS) / MIX_B_MOD;
    localparam int M12_W      = $clog2(MIX_B_MOD);

    // count * 255 / max_iterations
    localparam int DVD_W = ITER_BITS + COLOR_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_X,
        REG_TOP_Y,
        REG_X_STEP,
        REG_Y_STEP,
        REG_MAX_ITER,
        REG_SCHEME
    } t_reg_idx;

    typedef enum logic [SCHEME_BITS-1:0] {
        SCH_BLACK,
        SCH_GREEN,
        SCH_BLUE,
        SCH_MIX
    } t_scheme;

    typedef struct packed {
        logic [PIX_BITS-1:0] column;
        logic [PIX_BITS-1:0] row;
    } t_pixel;

    typedef struct packed {
        logic [ITER_BITS-1:0]  iteration_count;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_colour;

    typedef struct packed {
        logic                         start;
        logic signed [COORD_BITS-1:0] cr;
        logic signed [COORD_BITS-1:0] ci;
        logic [ITER_BITS-1:0]         limit;
    } t_iter_cmd;

    typedef struct packed {
        logic                 done;
        logic [ITER_BITS-1:0] count;
        logic [M12_W-1:0]     m12;
    } t_iter_res;

    // one slot of the divider chain: partial remainder, dividend bits out, quotient in
    typedef struct packed {
        logic                  vld;
        logic [ITER_BITS-1:0]  rem;
        logic [COLOR_BITS-1:0] bits;
    } t_div_lane;

endpackage
`default_nettype wire

// ----- rtl/mbe_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_div_cell
// One restoring-division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module mbe_div_cell (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire [mbe_pkg::ITER_BITS-1:0]     i_divisor,
    input  mbe_pkg::t_div_lane               i_lane,
    output mbe_pkg::t_div_lane               o_lane
);

    mbe_pkg::t_div_lane r_lane, n_lane;

    logic [mbe_pkg::ITER_BITS:0] w_trial;
    logic [mbe_pkg::ITER_BITS:0] w_diff;
    logic                        w_ge;

    assign w_trial = {i_lane.rem, i_lane.bits[mbe_pkg::COLOR_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_comb begin
        n_lane.vld  = i_lane.vld;
        n_lane.rem  = w_ge ? w_diff[mbe_pkg::ITER_BITS-1:0]
                           : w_trial[mbe_pkg::ITER_BITS-1:0];
        n_lane.bits = {i_lane.bits[mbe_pkg::COLOR_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane.vld <= n_lane.vld;
        end
        if (i_en) begin
            r_lane.rem  <= n_lane.rem;
            r_lane.bits <= n_lane.bits;
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

// ----- rtl/mbe_iter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_iter
// Escape-time loop: one z = z*z + c iteration per cycle, three multipliers.
// ----------------------------------------------------------------------------
module mbe_iter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mbe_pkg::t_iter_cmd  i_cmd,
    output mbe_pkg::t_iter_res  o_res
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_state, n_state;
    mbe_pkg::t_iter_res r_res, n_res;

    logic signed [mbe_pkg::COORD_BITS-1:0] r_cr, n_cr;
    logic signed [mbe_pkg::COORD_BITS-1:0] r_ci, n_ci;
    logic [mbe_pkg::ITER_BITS-1:0]         r_limit, n_limit;
    logic [mbe_pkg::SQ_W-1:0]              r_sr, n_sr;
    logic [mbe_pkg::SQ_W-1:0]              r_si, n_si;
    logic signed [mbe_pkg::P_W-1:0]        r_p, n_p;
    logic [mbe_pkg::ITER_BITS-1:0]         r_count, n_count;
    logic [mbe_pkg::M12_W-1:0]             r_m12, n_m12;
    logic                                  r_chk, n_chk;

    logic [mbe_pkg::SUM_W-1:0]         w_sum;
    logic                              w_esc_sum;
    logic [mbe_pkg::ITER_BITS-1:0]     w_cnt_now;
    logic [mbe_pkg::M12_W-1:0]         w_m12_now;
    logic                              w_at_limit;
    logic signed [mbe_pkg::NW-1:0]     w_nr, w_ni;
    logic                              w_out_bnd;
    logic signed [mbe_pkg::Z_W-1:0]    w_zr, w_zi;
    logic signed [mbe_pkg::PROD_W-1:0] w_rr, w_ii, w_ri;

    // r_chk: the stored squares belong to a candidate still to be checked against 4
    assign w_sum     = mbe_pkg::SUM_W'(r_sr) + mbe_pkg::SUM_W'(r_si);
    assign w_esc_sum = r_chk && (w_sum > mbe_pkg::SQ_FOUR);

    assign w_cnt_now  = r_chk ? r_count + mbe_pkg::ITER_BITS'(1) : r_count;
    assign w_m12_now  = !r_chk ? r_m12
                      : (r_m12 == mbe_pkg::M12_W'(mbe_pkg::MIX_B_MOD - 1)) ? '0
                      : r_m12 + mbe_pkg::M12_W'(1);
    assign w_at_limit = (w_cnt_now == r_limit);

    assign w_nr = signed'(mbe_pkg::NW'(r_sr)) - signed'(mbe_pkg::NW'(r_si))
                + mbe_pkg::NW'(r_cr);
    assign w_ni = (mbe_pkg::NW'(r_p) <<< 1) + mbe_pkg::NW'(r_ci);

    assign w_out_bnd = (w_nr > mbe_pkg::Z_TWO) || (w_nr < -mbe_pkg::Z_TWO)
                    || (w_ni > mbe_pkg::Z_TWO) || (w_ni < -mbe_pkg::Z_TWO);

    // only used when in bounds, where the narrow form is exact
    assign w_zr = w_nr[mbe_pkg::Z_W-1:0];
    assign w_zi = w_ni[mbe_pkg::Z_W-1:0];
    assign w_rr = w_zr * w_zr;
    assign w_ii = w_zi * w_zi;
    assign w_ri = w_zr * w_zi;

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_res.done = 1'b0;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_limit  = r_limit;
        n_sr     = r_sr;
        n_si     = r_si;
        n_p      = r_p;
        n_count  = r_count;
        n_m12    = r_m12;
        n_chk    = r_chk;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_state = S_RUN;
                    n_cr    = i_cmd.cr;
                    n_ci    = i_cmd.ci;
                    n_limit = i_cmd.limit;
                    n_sr    = '0;
                    n_si    = '0;
                    n_p     = '0;
                    n_count = '0;
                    n_m12   = '0;
                    n_chk   = 1'b0;
                end
            end
            S_RUN: begin
                if (w_esc_sum) begin
                    n_state     = S_IDLE;
                    n_res.done  = 1'b1;
                    n_res.count = r_count;
                    n_res.m12   = r_m12;
                end else if (w_at_limit || w_out_bnd) begin
                    n_state     = S_IDLE;
                    n_res.done  = 1'b1;
                    n_res.count = w_cnt_now;
                    n_res.m12   = w_m12_now;
                end else begin
                    // floor of the Q-format products: arithmetic shift of the full product
                    n_sr    = w_rr[mbe_pkg::FRAC_BITS +: mbe_pkg::SQ_W];
                    n_si    = w_ii[mbe_pkg::FRAC_BITS +: mbe_pkg::SQ_W];
                    n_p     = w_ri[mbe_pkg::FRAC_BITS +: mbe_pkg::P_W];
                    n_count = w_cnt_now;
                    n_m12   = w_m12_now;
                    n_chk   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_limit <= n_limit;
        r_sr    <= n_sr;
        r_si    <= n_si;
        r_p     <= n_p;
        r_count <= n_count;
        r_m12   <= n_m12;
        r_chk   <= n_chk;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ----- rtl/mandelbrot_escape_time_colorizer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_colorizer_top
// Takes a pixel (column, row), maps it to c in signed Q4.28, runs the escape
// loop z = z*z + c from zero and returns the iteration count with an RGB
// colour. One pixel is in flight at a time. The escape loop completes one
// complex iteration per cycle using three multipliers, and the eight-cell
// divider chain scales the count for the green and blue schemes. A new pixel
// is taken as soon as the previous result has moved into the output register,
// even if that result has not yet been collected. Configuration is written
// through the plain write port; the user must write it only while idle, as
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_colorizer_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  mbe_pkg::t_pixel                   i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output mbe_pkg::t_colour                  o_out_data,
    input  wire                               i_cfg_we,
    input  wire [mbe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [mbe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic signed [mbe_pkg::CFG_COORD_BITS-1:0] r_left_x, r_top_y;
    logic [mbe_pkg::STEP_BITS-1:0]             r_x_step, r_y_step;
    logic [mbe_pkg::ITER_BITS-1:0]             r_max_iter;
    mbe_pkg::t_scheme                          r_scheme;

    logic                                   r_busy;
    logic                                   r_map_vld;
    logic signed [mbe_pkg::COORD_BITS-1:0]  r_cr, r_ci;
    logic [mbe_pkg::ITER_BITS-1:0]          r_count;
    logic [mbe_pkg::M12_W-1:0]              r_m12;
    logic                                   r_out_vld;
    mbe_pkg::t_colour                       r_out_data;

    logic                                   w_accept;
    logic [mbe_pkg::MAP_W-1:0]              w_col_off, w_row_off;
    logic signed [mbe_pkg::MAP_W-1:0]       w_re_sum, w_im_sum;
    mbe_pkg::t_iter_cmd                     w_cmd;
    mbe_pkg::t_iter_res                     w_res;
    logic [mbe_pkg::DVD_W-1:0]              w_dvd;
    mbe_pkg::t_div_lane                     w_lane [0:mbe_pkg::COLOR_BITS];
    logic                                   w_chain_en;
    logic                                   w_load;
    logic                                   w_black;
    mbe_pkg::t_colour                       w_colour;

    function automatic logic signed [mbe_pkg::COORD_BITS-1:0] sat_coord(
        input logic signed [mbe_pkg::MAP_W-1:0] v
    );
        logic [mbe_pkg::MAP_W-mbe_pkg::COORD_BITS:0] top;
        top = v[mbe_pkg::MAP_W-1:mbe_pkg::COORD_BITS-1];
        if ((&top) || !(|top)) begin
            return v[mbe_pkg::COORD_BITS-1:0];
        end else if (v[mbe_pkg::MAP_W-1]) begin
            return {1'b1, {(mbe_pkg::COORD_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(mbe_pkg::COORD_BITS-1){1'b1}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_x   <= 32'shE000_0000;
            r_top_y    <= 32'sh2000_0000;
            r_x_step   <= 31'h0010_0000;
            r_y_step   <= 31'h0010_0000;
            r_max_iter <= 10'd255;
            r_scheme   <= mbe_pkg::SCH_BLACK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbe_pkg::REG_LEFT_X:   r_left_x   <= i_cfg_data;
                mbe_pkg::REG_TOP_Y:    r_top_y    <= i_cfg_data;
                mbe_pkg::REG_X_STEP:   r_x_step   <= i_cfg_data[mbe_pkg::STEP_BITS-1:0];
                mbe_pkg::REG_Y_STEP:   r_y_step   <= i_cfg_data[mbe_pkg::STEP_BITS-1:0];
                mbe_pkg::REG_MAX_ITER: r_max_iter <= i_cfg_data[mbe_pkg::ITER_BITS-1:0];
                mbe_pkg::REG_SCHEME: begin
                    r_scheme <= mbe_pkg::t_scheme'(i_cfg_data[mbe_pkg::SCHEME_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && !r_busy;

    // pixel to complex coordinate
    assign w_col_off = mbe_pkg::MAP_W'(i_in_data.column) * mbe_pkg::MAP_W'(r_x_step);
    assign w_row_off = mbe_pkg::MAP_W'(i_in_data.row) * mbe_pkg::MAP_W'(r_y_step);
    assign w_re_sum  = mbe_pkg::MAP_W'(r_left_x) + signed'(w_col_off);
    assign w_im_sum  = mbe_pkg::MAP_W'(r_top_y) - signed'(w_row_off);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cr <= sat_coord(w_re_sum);
            r_ci <= sat_coord(w_im_sum);
        end
        if (w_res.done) begin
            r_count <= w_res.count;
            r_m12   <= w_res.m12;
        end
        if (w_load) begin
            r_out_data <= w_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_map_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_map_vld <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        w_cmd.start = r_map_vld;
        w_cmd.cr    = r_cr;
        w_cmd.ci    = r_ci;
        w_cmd.limit = r_max_iter;
    end

    mbe_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_res   (w_res)
    );

    // count * 255 = (count << 8) - count, split into leading remainder and shifted bits
    assign w_dvd = {w_res.count, mbe_pkg::COLOR_BITS'(0)} - mbe_pkg::DVD_W'(w_res.count);

    always_comb begin
        w_lane[0].vld  = w_res.done;
        w_lane[0].rem  = w_dvd[mbe_pkg::DVD_W-1:mbe_pkg::COLOR_BITS];
        w_lane[0].bits = w_dvd[mbe_pkg::COLOR_BITS-1:0];
    end

    // hold the chain while the finished transaction waits for the output register
    assign w_chain_en = !(w_lane[mbe_pkg::COLOR_BITS].vld && r_out_vld && !i_out_ready);
    assign w_load     = w_lane[mbe_pkg::COLOR_BITS].vld && w_chain_en;

    for (genvar gi = 0; gi < mbe_pkg::COLOR_BITS; gi++) begin : g_cell
        mbe_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_chain_en),
            .i_divisor (r_max_iter),
            .i_lane    (w_lane[gi]),
            .o_lane    (w_lane[gi+1])
        );
    end

    assign w_black = (r_count == '0) || (r_count == r_max_iter);

    always_comb begin
        w_colour.iteration_count = r_count;
        w_colour.red             = '0;
        w_colour.green           = '0;
        w_colour.blue            = '0;
        if (!w_black) begin
            case (r_scheme)
                mbe_pkg::SCH_MIX: begin
                    w_colour.red   = mbe_pkg::COLOR_BITS'(r_count % mbe_pkg::MIX_R_MOD)
                                   * mbe_pkg::COLOR_BITS'(mbe_pkg::MIX_R_STEP);
                    w_colour.green = mbe_pkg::COLOR_BITS'(r_count % mbe_pkg::MIX_G_MOD)
                                   * mbe_pkg::COLOR_BITS'(mbe_pkg::MIX_G_STEP);
                    w_colour.blue  = mbe_pkg::COLOR_BITS'(r_m12)
                                   * mbe_pkg::COLOR_BITS'(mbe_pkg::MIX_B_STEP);
                end
                mbe_pkg::SCH_BLUE: begin
                    w_colour.blue = w_lane[mbe_pkg::COLOR_BITS].bits;
                end
                mbe_pkg::SCH_GREEN: begin
                    w_colour.green = w_lane[mbe_pkg::COLOR_BITS].bits;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire
